@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/fiwc_pkg.sv @@
// Package for the face interpolation weight check unit.
// Holds the item codes, flag struct, sequencer states and fixed constants.
`timescale 1ns / 1ps

package fiwc_pkg;

  // Weight format: unsigned Q1.16
  localparam int WEIGHT_W = 17;
  localparam int FRAC_W   = 16;
  localparam int DIV_CNT_W = 4;
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [WEIGHT_W-1:0] MIN_WEIGHT_RESET = 17'd3277;

  // Job queue between front and back end
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Vector kinds carried on the op field
  typedef enum logic [1:0] {
    OP_FACE_CENTRE = 2'd0,
    OP_AREA        = 2'd1,
    OP_OWNER       = 2'd2,
    OP_NEIGHBOUR   = 2'd3
  } vec_op_t;

  // Per-face flags sampled with the neighbour centre
  typedef struct packed {
    logic face_kind;
    logic is_master;
    logic first_face;
  } face_flags_t;

  localparam int FLAGS_W = $bits(face_flags_t);

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_PREP,
    ST_DIV,
    ST_STAT
  } back_state_t;

endpackage

@@ hdl/fiwc_front.sv @@
// Front end: accepts vector items, holds face/area/owner vectors, forms
// the difference vectors and pushes one job per face. Uses fiwc_pkg.
`timescale 1ns / 1ps

module fiwc_front
  import fiwc_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int JOB_W = 9 * COORD_BITS + 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic signed [COORD_BITS-1:0] vec_x,
  input  logic signed [COORD_BITS-1:0] vec_y,
  input  logic signed [COORD_BITS-1:0] vec_z,
  input  logic                         face_kind,
  input  logic                         is_master,
  input  logic                         first_face,
  input  logic                         q_full,
  output logic                         push,
  output logic [JOB_W-1:0]             job,
  output face_flags_t                  flags
);

  localparam int C = COORD_BITS;
  localparam int OWN_BASE = 3 * C;
  localparam int NEI_BASE = 3 * C + 3 * (C + 1);

  logic signed [C-1:0] fc   [3];
  logic signed [C-1:0] area [3];
  logic signed [C-1:0] oc   [3];
  logic signed [C-1:0] vin  [3];
  logic signed [C:0]   d_own [3];
  logic signed [C:0]   d_nei [3];
  logic                accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (vec_op_t'(op) == OP_NEIGHBOUR);

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;

  // Store the vector of each accepted transaction by kind
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        fc[i]   <= '0;
        area[i] <= '0;
        oc[i]   <= '0;
      end
    end else if (accept) begin
      unique case (vec_op_t'(op))
        OP_FACE_CENTRE: for (int i = 0; i < 3; i++) fc[i] <= vin[i];
        OP_AREA:        for (int i = 0; i < 3; i++) area[i] <= vin[i];
        OP_OWNER:       for (int i = 0; i < 3; i++) oc[i] <= vin[i];
        OP_NEIGHBOUR:   ;
        default:        ;
      endcase
    end
  end

  // Form difference vectors and pack the job
  always_comb begin
    job = '0;
    for (int i = 0; i < 3; i++) begin
      d_own[i] = (C+1)'(fc[i]) - (C+1)'(oc[i]);
      d_nei[i] = (C+1)'(vin[i]) - (C+1)'(fc[i]);
      job[i*C +: C]                 = area[i];
      job[OWN_BASE + i*(C+1) +: C+1] = d_own[i];
      job[NEI_BASE + i*(C+1) +: C+1] = d_nei[i];
    end
  end

  assign flags.face_kind  = face_kind;
  assign flags.is_master  = is_master;
  assign flags.first_face = first_face;

endmodule

@@ hdl/fiwc_queue.sv @@
// Short job queue between front and back end, register storage.
// Depth and pointer width come from fiwc_pkg.
`timescale 1ns / 1ps

module fiwc_queue
  import fiwc_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0]    store [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = store[rd_ptr];

  // Write entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy; hold the count when both or neither move
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/fiwc_back.sv @@
// Back end: shared multiplier for the two dot products, one-bit-per-cycle
// divider, statistics and output register. Uses fiwc_pkg.
`timescale 1ns / 1ps

module fiwc_back
  import fiwc_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FACE_COUNT_BITS = 20,
  parameter int JOB_W = 9 * COORD_BITS + 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         pop,
  input  logic [JOB_W-1:0]             job,
  input  face_flags_t                  flags,
  input  logic [WEIGHT_W-1:0]          min_weight,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [WEIGHT_W-1:0]          face_weight,
  output logic                         below_limit,
  output logic [WEIGHT_W-1:0]          min_seen,
  output logic [FACE_COUNT_BITS+16:0]  weight_sum,
  output logic [FACE_COUNT_BITS:0]     master_count,
  output logic [FACE_COUNT_BITS:0]     error_count
);

  localparam int C        = COORD_BITS;
  localparam int OWN_BASE = 3 * C;
  localparam int NEI_BASE = 3 * C + 3 * (C + 1);
  localparam int PROD_W   = 2 * C + 1;
  localparam int ACC_W    = 2 * C + 3;
  localparam int MAG_W    = 2 * C + 1;
  localparam int SUM_W    = 2 * C + 2;
  localparam int REM_W    = SUM_W + 1;
  localparam int CNT_W    = FACE_COUNT_BITS + 1;
  localparam int TOT_W    = FACE_COUNT_BITS + 17;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(1) << FACE_COUNT_BITS;
  localparam logic [TOT_W-1:0] SUM_CAP = TOT_W'(1) << (FACE_COUNT_BITS + 16);
  localparam logic [2:0] MUL_LAST = 3'd6;

  back_state_t state, state_next;

  logic [JOB_W-1:0]        job_q;
  face_flags_t             flags_q;
  logic [2:0]              step;
  logic signed [C-1:0]     mul_a;
  logic signed [C:0]       mul_d;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_own;
  logic signed [ACC_W-1:0] acc_nei;
  logic signed [ACC_W-1:0] abs_own;
  logic signed [ACC_W-1:0] abs_nei;
  logic [MAG_W-1:0]        mag_own;
  logic [MAG_W-1:0]        mag_nei;
  logic                    sum_zero;
  logic [SUM_W-1:0]        divisor;
  logic [REM_W-1:0]        rem;
  logic [REM_W-1:0]        rem_sh;
  logic                    rem_ge;
  logic [FRAC_W-1:0]       quo;
  logic [DIV_CNT_W-1:0]    bit_cnt;
  logic [WEIGHT_W-1:0]     weight;

  logic                    mul_run;
  logic                    stat_fire;

  logic [WEIGHT_W-1:0]     min_acc;
  logic [TOT_W-1:0]        sum_acc;
  logic [CNT_W-1:0]        master_acc;
  logic [CNT_W-1:0]        error_acc;
  logic [WEIGHT_W-1:0]     base_min;
  logic [TOT_W-1:0]        base_sum;
  logic [CNT_W-1:0]        base_master;
  logic [CNT_W-1:0]        base_err;
  logic                    below;
  logic [TOT_W:0]          sum_ext;
  logic [WEIGHT_W-1:0]     min_acc_next;
  logic [TOT_W-1:0]        sum_acc_next;
  logic [CNT_W-1:0]        master_acc_next;
  logic [CNT_W-1:0]        error_acc_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = flags.face_kind ? ST_MUL : ST_STAT;
        end
      end
      ST_MUL:  if (step == MUL_LAST) state_next = ST_ABS;
      ST_ABS:  state_next = ST_PREP;
      ST_PREP: state_next = sum_zero ? ST_STAT : ST_DIV;
      ST_DIV:  if (bit_cnt == DIV_CNT_W'(FRAC_W - 1)) state_next = ST_STAT;
      ST_STAT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    pop       = 1'b0;
    mul_run   = 1'b0;
    stat_fire = 1'b0;
    unique case (state)
      ST_IDLE: pop = !q_empty;
      ST_MUL:  mul_run = 1'b1;
      ST_STAT: stat_fire = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick multiplier operands: owner products first, then neighbour products
  always_comb begin
    mul_a = '0;
    mul_d = '0;
    unique case (step)
      3'd0: begin mul_a = job_q[0*C +: C]; mul_d = job_q[OWN_BASE + 0*(C+1) +: C+1]; end
      3'd1: begin mul_a = job_q[1*C +: C]; mul_d = job_q[OWN_BASE + 1*(C+1) +: C+1]; end
      3'd2: begin mul_a = job_q[2*C +: C]; mul_d = job_q[OWN_BASE + 2*(C+1) +: C+1]; end
      3'd3: begin mul_a = job_q[0*C +: C]; mul_d = job_q[NEI_BASE + 0*(C+1) +: C+1]; end
      3'd4: begin mul_a = job_q[1*C +: C]; mul_d = job_q[NEI_BASE + 1*(C+1) +: C+1]; end
      3'd5: begin mul_a = job_q[2*C +: C]; mul_d = job_q[NEI_BASE + 2*(C+1) +: C+1]; end
      default: ;
    endcase
  end

  // Magnitudes of the two dot products
  assign abs_own  = acc_own[ACC_W-1] ? -acc_own : acc_own;
  assign abs_nei  = acc_nei[ACC_W-1] ? -acc_nei : acc_nei;
  assign sum_zero = (mag_own == '0) && (mag_nei == '0);

  // One restoring division step
  assign rem_sh = {rem[REM_W-2:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  // Datapath: latch job, multiply-accumulate, prepare and divide
  always_ff @(posedge clk) begin
    if (pop) begin
      job_q   <= job;
      flags_q <= flags;
      step    <= '0;
      acc_own <= '0;
      acc_nei <= '0;
      if (!flags.face_kind) begin
        weight <= ONE_Q16;
      end
    end
    if (mul_run) begin
      step <= step + 3'd1;
      prod <= PROD_W'(mul_a * mul_d);
      if (step != 3'd0) begin
        if (step <= 3'd3) begin
          acc_own <= acc_own + ACC_W'(prod);
        end else begin
          acc_nei <= acc_nei + ACC_W'(prod);
        end
      end
    end
    if (state == ST_ABS) begin
      mag_own <= abs_own[MAG_W-1:0];
      mag_nei <= abs_nei[MAG_W-1:0];
    end
    if (state == ST_PREP) begin
      divisor <= SUM_W'(mag_own) + SUM_W'(mag_nei);
      rem     <= (mag_own >= mag_nei) ? REM_W'(mag_nei) : REM_W'(mag_own);
      quo     <= '0;
      bit_cnt <= '0;
      if (sum_zero) begin
        weight <= '0;
      end
    end
    if (state == ST_DIV) begin
      rem     <= rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
      quo     <= {quo[FRAC_W-2:0], rem_ge};
      bit_cnt <= bit_cnt + 1'b1;
      if (bit_cnt == DIV_CNT_W'(FRAC_W - 1)) begin
        weight <= {1'b0, quo[FRAC_W-2:0], rem_ge};
      end
    end
  end

  // Statistics update for the finished face
  always_comb begin
    base_min    = flags_q.first_face ? ONE_Q16 : min_acc;
    base_sum    = flags_q.first_face ? '0 : sum_acc;
    base_master = flags_q.first_face ? '0 : master_acc;
    base_err    = flags_q.first_face ? '0 : error_acc;

    below = weight < min_weight;
    error_acc_next = base_err;
    if (below && (base_err < CNT_CAP)) begin
      error_acc_next = base_err + 1'b1;
    end

    sum_ext         = {1'b0, base_sum} + (TOT_W+1)'(weight);
    min_acc_next    = base_min;
    sum_acc_next    = base_sum;
    master_acc_next = base_master;
    if (flags_q.is_master) begin
      if (weight < base_min) begin
        min_acc_next = weight;
      end
      sum_acc_next = (sum_ext > {1'b0, SUM_CAP}) ? SUM_CAP : sum_ext[TOT_W-1:0];
      if (base_master < CNT_CAP) begin
        master_acc_next = base_master + 1'b1;
      end
    end
  end

  // Hold the statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      min_acc    <= ONE_Q16;
      sum_acc    <= '0;
      master_acc <= '0;
      error_acc  <= '0;
    end else if (stat_fire) begin
      min_acc    <= min_acc_next;
      sum_acc    <= sum_acc_next;
      master_acc <= master_acc_next;
      error_acc  <= error_acc_next;
    end
  end

  // Output register: load on completion, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat_fire) begin
      face_weight  <= weight;
      below_limit  <= below;
      min_seen     <= min_acc_next;
      weight_sum   <= sum_acc_next;
      master_count <= master_acc_next;
      error_count  <= error_acc_next;
    end
  end

endmodule

@@ hdl/face_interpolation_weight_check_unit.sv @@
// Top level of the face interpolation weight check unit.
// Instantiates fiwc_front, fiwc_queue and fiwc_back; uses fiwc_pkg.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    op, vec_x, vec_y, vec_z, face_kind,
//                                   is_master, first_face
//   out      out_valid / out_ready  face_weight, below_limit, min_seen,
//                                   weight_sum, master_count, error_count
//   cfg      cfg_valid / cfg_ready  cfg_data (min_weight)
//
// The front end stores vector items by kind. A computed face holds the
// back end through job take, the shared multiplier, forming magnitudes
// and divisor, the one-bit-per-cycle divider and the update step; a face
// with zero distance sum skips the divider, and an uncoupled face goes
// from job take straight to the update. A two-entry job queue lets the
// front end keep taking items meanwhile. Reset is synchronous and clears
// vectors and statistics and sets min_weight to its reset value; a stalled
// output holds the back end in its update step.
`timescale 1ns / 1ps

module face_interpolation_weight_check_unit
  import fiwc_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FACE_COUNT_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [WEIGHT_W-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic signed [COORD_BITS-1:0] vec_x,
  input  logic signed [COORD_BITS-1:0] vec_y,
  input  logic signed [COORD_BITS-1:0] vec_z,
  input  logic                         face_kind,
  input  logic                         is_master,
  input  logic                         first_face,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [WEIGHT_W-1:0]          face_weight,
  output logic                         below_limit,
  output logic [WEIGHT_W-1:0]          min_seen,
  output logic [FACE_COUNT_BITS+16:0]  weight_sum,
  output logic [FACE_COUNT_BITS:0]     master_count,
  output logic [FACE_COUNT_BITS:0]     error_count
);

  localparam int JOB_W = 9 * COORD_BITS + 6;
  localparam int Q_W   = JOB_W + FLAGS_W;

  logic [WEIGHT_W-1:0] min_weight;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  logic [JOB_W-1:0]    job_in;
  face_flags_t         flags_in;
  logic [Q_W-1:0]      q_out;

  // Threshold register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_weight <= MIN_WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_weight <= cfg_data;
    end
  end

  fiwc_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .face_kind  (face_kind),
    .is_master  (is_master),
    .first_face (first_face),
    .q_full     (q_full),
    .push       (push),
    .job        (job_in),
    .flags      (flags_in)
  );

  fiwc_queue #(
    .W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({flags_in, job_in}),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  fiwc_back #(
    .COORD_BITS      (COORD_BITS),
    .FACE_COUNT_BITS (FACE_COUNT_BITS),
    .JOB_W           (JOB_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .pop          (pop),
    .job          (q_out[JOB_W-1:0]),
    .flags        (face_flags_t'(q_out[Q_W-1:JOB_W])),
    .min_weight   (min_weight),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .face_weight  (face_weight),
    .below_limit  (below_limit),
    .min_seen     (min_seen),
    .weight_sum   (weight_sum),
    .master_count (master_count),
    .error_count  (error_count)
  );

endmodule

@@ hdl/fiwc_checker.sv @@
// Port-level checker for the face interpolation weight check unit.
// Uses assert_macros.svh; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fiwc_checker #(
  parameter int FACE_COUNT_BITS = 20
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [16:0]                 face_weight,
  input logic [16:0]                 min_seen,
  input logic [FACE_COUNT_BITS:0]    master_count,
  input logic [FACE_COUNT_BITS:0]    error_count
);

  localparam logic [FACE_COUNT_BITS:0] CNT_CAP =
    (FACE_COUNT_BITS+1)'(1) << FACE_COUNT_BITS;

  // A stalled result stays put
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(face_weight), "result changed while stalled")

  // A computed weight is at most one half; only uncoupled faces reach one
  `ASSERT_CLK(a_weight_range, out_valid |-> (face_weight <= 17'd32768 || face_weight == 17'd65536), "face weight out of range")

  // Counters saturate at their cap
  `ASSERT_CLK(a_count_cap, out_valid |-> (master_count <= CNT_CAP && error_count <= CNT_CAP), "counter beyond cap")

  // With no master face the minimum stays at one
  `ASSERT_CLK(a_min_empty, out_valid && master_count == '0 |-> min_seen == 17'd65536, "minimum set without master face")

  // Reset drops any pending transaction
  `ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind face_interpolation_weight_check_unit fiwc_checker #(
  .FACE_COUNT_BITS (FACE_COUNT_BITS)
) u_fiwc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .face_weight  (face_weight),
  .min_seen     (min_seen),
  .master_count (master_count),
  .error_count  (error_count)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for face_interpolation_weight_check_unit.
// Depends on fiwc_pkg and the RTL under hdl/; drives random and directed faces
// through a queue-fed driver and checks every result against its own predictor.
`timescale 1ns / 1ps

module tb_top;
  import fiwc_pkg::*;

  localparam int COORD_W = 24;
  localparam int COUNT_BITS = 20;
  localparam int SUM_W = COUNT_BITS + 17;
  localparam int CNT_W = COUNT_BITS + 1;
  localparam longint unsigned SUM_CAP = 64'd1 << (COUNT_BITS + 16);
  localparam longint unsigned CNT_CAP = 64'd1 << COUNT_BITS;
  localparam logic signed [COORD_W-1:0] MAXC = 24'sh7fffff;
  localparam logic signed [COORD_W-1:0] MINC = 24'sh800000;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    vec_op_t                   op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    bit                        face_kind;
    bit                        is_master;
    bit                        first_face;
  } vec_item_t;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic                below;
    logic [WEIGHT_W-1:0] min_w;
    logic [SUM_W-1:0]    sum_w;
    logic [CNT_W-1:0]    masters;
    logic [CNT_W-1:0]    errors;
  } face_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [WEIGHT_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] op;
  logic signed [COORD_W-1:0] vec_x, vec_y, vec_z;
  logic face_kind, is_master, first_face;
  logic out_valid;
  logic out_ready;
  logic [WEIGHT_W-1:0] face_weight;
  logic below_limit;
  logic [WEIGHT_W-1:0] min_seen;
  logic [SUM_W-1:0] weight_sum;
  logic [CNT_W-1:0] master_count;
  logic [CNT_W-1:0] error_count;

  // Predictor state: vector registers, statistics and threshold
  logic signed [COORD_W-1:0] centre_reg [3];
  logic signed [COORD_W-1:0] area_reg [3];
  logic signed [COORD_W-1:0] owner_reg [3];
  logic [WEIGHT_W-1:0] min_acc;
  logic [SUM_W-1:0]    sum_acc;
  logic [CNT_W-1:0]    master_acc;
  logic [CNT_W-1:0]    error_acc;
  logic [WEIGHT_W-1:0] threshold;

  vec_item_t    vector_items_q [$];
  face_result_t face_results_due [$];
  vec_item_t    cur_item;
  face_result_t new_result;
  bit           drv_busy;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           mismatches;
  int           cycle_count;

  face_interpolation_weight_check_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .vec_x        (vec_x),
    .vec_y        (vec_y),
    .vec_z        (vec_z),
    .face_kind    (face_kind),
    .is_master    (is_master),
    .first_face   (first_face),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .face_weight  (face_weight),
    .below_limit  (below_limit),
    .min_seen     (min_seen),
    .weight_sum   (weight_sum),
    .master_count (master_count),
    .error_count  (error_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Update the predictor with one accepted vector item; return 1 when a face ends
  function automatic bit weigh_item(input vec_item_t it, output face_result_t res);
    logic signed [COORD_W-1:0] nei [3];
    longint own_dot, nei_dot, fcv;
    logic [127:0] own_mag, nei_mag, dist_sum, near_mag;
    logic [WEIGHT_W-1:0] w;
    logic [SUM_W:0] sum_next;
    nei[0] = it.x;
    nei[1] = it.y;
    nei[2] = it.z;
    res = '{default: '0};
    case (it.op)
      OP_FACE_CENTRE: begin
        centre_reg = nei;
        return 1'b0;
      end
      OP_AREA: begin
        area_reg = nei;
        return 1'b0;
      end
      OP_OWNER: begin
        owner_reg = nei;
        return 1'b0;
      end
      default: ;
    endcase

    // Clear statistics ahead of the face carrying the first-face mark
    if (it.first_face) begin
      min_acc = ONE_Q16;
      sum_acc = '0;
      master_acc = '0;
      error_acc = '0;
    end

    // Weight: nearer projected distance over the sum, truncated to Q1.16
    if (it.face_kind) begin
      own_dot = 0;
      nei_dot = 0;
      for (int i = 0; i < 3; i++) begin
        fcv = longint'(centre_reg[i]);
        own_dot += longint'(area_reg[i]) * (fcv - longint'(owner_reg[i]));
        nei_dot += longint'(area_reg[i]) * (longint'(nei[i]) - fcv);
      end
      own_mag = (own_dot < 0) ? -own_dot : own_dot;
      nei_mag = (nei_dot < 0) ? -nei_dot : nei_dot;
      dist_sum = own_mag + nei_mag;
      near_mag = (own_mag <= nei_mag) ? own_mag : nei_mag;
      w = (dist_sum == 0) ? '0 : WEIGHT_W'((near_mag << FRAC_W) / dist_sum);
    end else begin
      w = ONE_Q16;
    end

    res.below = (w < threshold);
    if (res.below && error_acc < CNT_CAP)
      error_acc++;
    if (it.is_master) begin
      if (w < min_acc)
        min_acc = w;
      sum_next = sum_acc + w;
      sum_acc = (sum_next > SUM_CAP) ? SUM_W'(SUM_CAP) : sum_next[SUM_W-1:0];
      if (master_acc < CNT_CAP)
        master_acc++;
    end

    res.weight = w;
    res.min_w = min_acc;
    res.sum_w = sum_acc;
    res.masters = master_acc;
    res.errors = error_acc;
    return 1'b1;
  endfunction

  // Driver: predict on acceptance, then present the next queued item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_busy = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (weigh_item(cur_item, new_result))
          face_results_due.push_back(new_result);
        drv_busy = 1'b0;
      end
      if (!drv_busy && vector_items_q.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_item = vector_items_q.pop_front();
        drv_busy = 1'b1;
        op <= cur_item.op;
        vec_x <= cur_item.x;
        vec_y <= cur_item.y;
        vec_z <= cur_item.z;
        face_kind <= cur_item.face_kind;
        is_master <= cur_item.is_master;
        first_face <= cur_item.first_face;
      end
      in_valid <= drv_busy;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (face_results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: weight %0d, sum %0d", $time,
                   face_weight, weight_sum);
        end else begin
          new_result = face_results_due.pop_front();
          check_field("face_weight", new_result.weight, face_weight);
          check_field("below_limit", new_result.below, below_limit);
          check_field("min_seen", new_result.min_w, min_seen);
          check_field("weight_sum", new_result.sum_w, weight_sum);
          check_field("master_count", new_result.masters, master_count);
          check_field("error_count", new_result.errors, error_count);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(input vec_op_t k, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z,
                           input bit kind, input bit master, input bit first);
    vec_item_t it;
    it.op = k;
    it.x = x;
    it.y = y;
    it.z = z;
    it.face_kind = kind;
    it.is_master = master;
    it.first_face = first;
    vector_items_q.push_back(it);
  endtask

  // Mix of extremes, small values near zero and full-range coordinates
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0: pick_coord = MINC;
      1: pick_coord = MAXC;
      2, 3: pick_coord = COORD_W'($urandom_range(2000) - 1000);
      default: pick_coord = COORD_W'($urandom());
    endcase
  endfunction

  // Mostly whole faces with random content, the rest stray single items
  task automatic push_random(input int n);
    logic signed [COORD_W-1:0] fc [3], ar [3], co [3], cn [3];
    int pushed;
    int shape;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(99) < 85) begin
        shape = $urandom_range(9);
        for (int i = 0; i < 3; i++) begin
          fc[i] = pick_coord();
          ar[i] = pick_coord();
          co[i] = pick_coord();
          cn[i] = (shape == 0) ? fc[i] : (shape == 1) ? co[i] : pick_coord();
        end
        push_item(OP_FACE_CENTRE, fc[0], fc[1], fc[2], $urandom_range(1),
                  $urandom_range(1), $urandom_range(1));
        push_item(OP_AREA, ar[0], ar[1], ar[2], $urandom_range(1),
                  $urandom_range(1), $urandom_range(1));
        push_item(OP_OWNER, co[0], co[1], co[2], $urandom_range(1),
                  $urandom_range(1), $urandom_range(1));
        push_item(OP_NEIGHBOUR, cn[0], cn[1], cn[2], $urandom_range(99) >= 15,
                  $urandom_range(1), $urandom_range(99) < 4);
        pushed += 4;
      end else begin
        push_item(vec_op_t'($urandom_range(3)), pick_coord(), pick_coord(),
                  pick_coord(), $urandom_range(1), $urandom_range(1),
                  $urandom_range(99) < 10);
        pushed += 1;
      end
    end
  endtask

  // Hold until every item is taken and every result is back, then let the block settle
  task automatic drain();
    while (vector_items_q.size() != 0 || drv_busy || face_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_weight(input logic [WEIGHT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_FACE_CENTRE;
    vec_x = '0;
    vec_y = '0;
    vec_z = '0;
    face_kind = 1'b0;
    is_master = 1'b0;
    first_face = 1'b0;
    out_ready = 1'b0;
    drv_busy = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 3; i++) begin
      centre_reg[i] = '0;
      area_reg[i] = '0;
      owner_reg[i] = '0;
    end
    min_acc = ONE_Q16;
    sum_acc = '0;
    master_acc = '0;
    error_acc = '0;
    threshold = MIN_WEIGHT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed faces under the reset threshold
    // Registers still clear after reset: zero distance sum
    push_item(OP_NEIGHBOUR, 0, 0, 0, 1, 1, 0);
    // Uncoupled boundary face
    push_item(OP_NEIGHBOUR, 24'sh123456, MINC, MAXC, 0, 1, 0);
    // Extreme coordinates giving equal distances
    push_item(OP_FACE_CENTRE, MAXC, MAXC, MAXC, 1, 1, 1);
    push_item(OP_AREA, MINC, MINC, MINC, 0, 0, 0);
    push_item(OP_OWNER, MINC, MINC, MINC, 1, 0, 1);
    push_item(OP_NEIGHBOUR, MINC, MINC, MINC, 1, 1, 0);
    // One third, truncated on the owner side
    push_item(OP_FACE_CENTRE, 0, 0, 0, 0, 0, 0);
    push_item(OP_AREA, 1, 0, 0, 0, 0, 0);
    push_item(OP_OWNER, -1, 0, 0, 0, 0, 0);
    push_item(OP_NEIGHBOUR, 2, 0, 0, 1, 1, 0);
    // Negative area, neighbour side nearer
    push_item(OP_AREA, 0, -3, 7, 0, 0, 0);
    push_item(OP_OWNER, 5, 900, -9, 0, 0, 0);
    push_item(OP_NEIGHBOUR, -1, -2, 3, 1, 1, 0);
    // Zero area vector
    push_item(OP_AREA, 0, 0, 0, 0, 0, 0);
    push_item(OP_NEIGHBOUR, 100, 200, 300, 1, 1, 0);
    // First-face mark clears statistics
    push_item(OP_NEIGHBOUR, 0, 0, 0, 0, 1, 1);
    // Flagged face that is not a master
    push_item(OP_NEIGHBOUR, 7, 8, 9, 1, 0, 0);
    // Overwrite the centre twice, mark on a non-master face
    push_item(OP_FACE_CENTRE, 11, -12, 13, 0, 0, 0);
    push_item(OP_FACE_CENTRE, -40, 50, -60, 0, 0, 0);
    push_item(OP_NEIGHBOUR, 30, 20, 10, 1, 0, 1);
    drain();

    // Zero threshold, no idling; hold the sender half way until all results return
    write_min_weight('0);
    push_random(90);
    drain();
    push_random(85);
    drain();

    // Threshold at one: all but uncoupled faces flagged; sender mostly idle
    write_min_weight(ONE_Q16);
    send_idle_pct = 88;
    recv_stall_pct = 0;
    push_random(175);
    drain();

    // Threshold above one: every face flagged; receiver mostly stalled
    write_min_weight('1);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    push_random(175);
    drain();

    // Random threshold of at most one half; both sides idle now and then
    write_min_weight(WEIGHT_W'($urandom_range(1, 32768)));
    send_idle_pct = 10;
    recv_stall_pct = 10;
    push_random(175);
    drain();

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
